[design/blae_pkg.sv]
// ----------------------------------------------------------------------------
// blae_pkg
// Types and codes shared by the bounded array list engine.
// ----------------------------------------------------------------------------
package blae_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_EDIT   = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
   localparam logic [OP_W-1:0] OP_GET    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          req_type;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] data_value;
   } blae_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_value;
      logic [FIDX_W-1:0]        found_index;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_full;
      logic                     is_empty;
   } blae_rsp_type;

endpackage

[design/blae_ram.sv]
// ----------------------------------------------------------------------------
// blae_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module blae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bounded_array_list_engine.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded ordered list of signed words with append, insert, edit, delete,
// find and get, built on one RAM and a small sequencer.
// ----------------------------------------------------------------------------
// Start is taken when busy is low; each item yields exactly one result, shown
// for one cycle under rsp_valid, and the receiver must take it then since it
// cannot stall. Append, edit, tail insert, last-entry delete, rejected items
// and unused codes finish at accept and strobe in the next cycle; get waits
// in S_GET, find scans in S_FIND, insert shifts in S_INS then writes in
// S_INS_LAST, and delete shifts in S_DEL. The list RAM has one read port and
// one write port, so insert, delete and find move through one entry per
// cycle. A new item may start in the cycle its predecessor's result is shown.
module bounded_array_list_engine
   import blae_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  blae_req_type      req_data,
   output logic              rsp_valid,
   output blae_rsp_type      rsp_data,
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS      = 3'd1;
   localparam logic [2:0] S_INS_LAST = 3'd2;
   localparam logic [2:0] S_DEL      = 3'd3;
   localparam logic [2:0] S_FIND     = 3'd4;
   localparam logic [2:0] S_GET      = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [CAP_W-1:0]   cap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   blae_rsp_type       rsp_ff, rsp_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   logic [DATA_W-1:0]  ram_wdata, ram_rdata;

   logic [CMP_W-1:0]   pos_ext, cnt_ext, cap_raw, cap_eff, fin_ext;
   logic [IDX_W-1:0]   pos_a, cnt_a, last_a;
   logic               full_now;
   logic               fin;
   logic [STATUS_W-1:0] fin_status;
   logic [DATA_W-1:0]  fin_rd;
   logic [IDX_W-1:0]   fin_idx;
   logic [CNT_W-1:0]   fin_count;
   logic [CMP_W-1:0]   fin_idx_ext;

   blae_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pos_ext  = CMP_W'(req_data.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign cap_raw  = CMP_W'(cap_ff);
   assign cap_eff  = (cap_raw > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_raw;
   assign full_now = (cnt_ext >= cap_eff);
   assign pos_a    = pos_ext[IDX_W-1:0];
   assign cnt_a    = cnt_ext[IDX_W-1:0];
   assign last_a   = cnt_a - 1'b1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = val_ff;
      ram_raddr  = '0;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_rd     = '0;
      fin_idx    = '0;
      fin_count  = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in = pos_a;
               val_in = req_data.data_value;
               case (req_data.req_type)
                  OP_APPEND: begin
                     fin = 1'b1;
                     if (full_now) begin
                        fin_status = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_a;
                        ram_wdata = req_data.data_value;
                        fin_count = count_ff + 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        fin        = 1'b1;
                        fin_status = ST_BADPOS;
                     end else if (full_now) begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                     end else if (pos_ext == cnt_ext) begin
                        fin       = 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = cnt_a;
                        ram_wdata = req_data.data_value;
                        fin_count = count_ff + 1'b1;
                     end else begin
                        idx_in    = last_a;
                        ram_raddr = last_a;
                        state_in  = S_INS;
                     end
                  end
                  OP_EDIT: begin
                     fin = 1'b1;
                     if (pos_ext >= cnt_ext) begin
                        fin_status = ST_BADPOS;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_a;
                        ram_wdata = req_data.data_value;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        fin        = 1'b1;
                        fin_status = ST_BADPOS;
                     end else if (pos_a == last_a) begin
                        fin       = 1'b1;
                        fin_count = count_ff - 1'b1;
                     end else begin
                        idx_in    = pos_a + 1'b1;
                        ram_raddr = pos_a + 1'b1;
                        state_in  = S_DEL;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = ST_NOTFOUND;
                     end else begin
                        idx_in    = '0;
                        ram_raddr = '0;
                        state_in  = S_FIND;
                     end
                  end
                  OP_GET: begin
                     if (pos_ext >= cnt_ext) begin
                        fin        = 1'b1;
                        fin_status = ST_BADPOS;
                     end else begin
                        ram_raddr = pos_a;
                        state_in  = S_GET;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff + 1'b1;
            ram_wdata = ram_rdata;
            if (idx_ff == pos_ff) begin
               state_in = S_INS_LAST;
            end else begin
               idx_in    = idx_ff - 1'b1;
               ram_raddr = idx_ff - 1'b1;
            end
         end
         S_INS_LAST: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = val_ff;
            fin       = 1'b1;
            fin_count = count_ff + 1'b1;
            state_in  = S_IDLE;
         end
         S_DEL: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff - 1'b1;
            ram_wdata = ram_rdata;
            if (idx_ff == last_a) begin
               fin       = 1'b1;
               fin_count = count_ff - 1'b1;
               state_in  = S_IDLE;
            end else begin
               idx_in    = idx_ff + 1'b1;
               ram_raddr = idx_ff + 1'b1;
            end
         end
         S_FIND: begin
            if (ram_rdata == val_ff) begin
               fin      = 1'b1;
               fin_idx  = idx_ff;
               state_in = S_IDLE;
            end else if (idx_ff == last_a) begin
               fin        = 1'b1;
               fin_status = ST_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               idx_in    = idx_ff + 1'b1;
               ram_raddr = idx_ff + 1'b1;
            end
         end
         S_GET: begin
            fin      = 1'b1;
            fin_rd   = ram_rdata;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         count_in = fin_count;
      end
   end

   assign fin_ext     = CMP_W'(fin_count);
   assign fin_idx_ext = CMP_W'(fin_idx);

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = fin;
      if (fin) begin
         rsp_in.status      = fin_status;
         rsp_in.read_value  = fin_rd;
         rsp_in.found_index = fin_idx_ext[FIDX_W-1:0];
         rsp_in.entry_count = fin_ext[COUNT_W-1:0];
         rsp_in.is_full     = (fin_ext >= cap_eff);
         rsp_in.is_empty    = (fin_count == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted item neither answered nor in progress");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while sequencer busy");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) ||
      (count_ff + 1'b1 == $past(count_ff)))
      else $error("entry count moved by more than one");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> rsp_valid)
      else $error("entry count changed without a result");

endmodule
